// ----- hw/rtl/dpsp_pkg.sv -----
// Shared types, codes and helper functions of the dynamic power state policy unit.
`default_nettype none

package dpsp_pkg;

    // Width of the idle-tick counter and of the stored samples.
    localparam int TimeBits  = 24;
    // Widths fixed by the interface.
    localparam int OutBits   = 24;
    localparam int DurBits   = 24;
    localparam int CfgBits   = 24;
    localparam int AlphaBits = 9;
    localparam int IndexBits = 3;
    localparam int WideBits  = (TimeBits > OutBits) ? TimeBits : OutBits;

    typedef logic [TimeBits-1:0]  t_time;
    typedef logic [OutBits-1:0]   t_out;
    typedef logic [AlphaBits-1:0] t_alpha;

    localparam t_time  TimeMax  = '1;
    localparam t_out   OutMax   = '1;
    localparam t_alpha AlphaOne = t_alpha'(256);
    localparam int     RoundBit = 128;

    typedef enum logic [2:0] {
        POL_TIMEOUT_IDLE  = 3'd0,
        POL_TIMEOUT_SLEEP = 3'd1,
        POL_LAST_ACTIVE   = 3'd2,
        POL_LAST_IDLE     = 3'd3,
        POL_EXP_AVERAGE   = 3'd4
    } t_policy;

    typedef enum logic [1:0] {
        PS_RUN   = 2'd0,
        PS_IDLE  = 2'd1,
        PS_SLEEP = 2'd2
    } t_pstate;

    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_ARRIVAL = 1'b1;

    localparam logic [IndexBits-1:0] REG_POLICY          = 3'd0;
    localparam logic [IndexBits-1:0] REG_TIMEOUT         = 3'd1;
    localparam logic [IndexBits-1:0] REG_THRESHOLD_IDLE  = 3'd2;
    localparam logic [IndexBits-1:0] REG_THRESHOLD_SLEEP = 3'd3;
    localparam logic [IndexBits-1:0] REG_ALPHA           = 3'd4;

    typedef struct packed {
        t_policy              policy;
        logic [CfgBits-1:0]   timeout;
        logic [CfgBits-1:0]   threshold_idle;
        logic [CfgBits-1:0]   threshold_sleep;
        t_alpha               alpha;
    } t_cfg;

    typedef struct packed {
        t_pstate cur_state;
        t_time   idle_ticks;
        t_time   last_sample;
        t_time   prediction;
        logic    pred_updated;
    } t_state;

    typedef struct packed {
        t_pstate power_state;
        logic    state_changed;
        t_out    predicted_idle;
    } t_result;

    // Clamp an incoming duration to the counter range.
    function automatic t_time sat_dur(input logic [DurBits-1:0] v);
        logic [WideBits-1:0] wide;
        wide = WideBits'(v);
        if (wide > WideBits'(TimeMax)) begin
            return TimeMax;
        end
        return TimeBits'(wide);
    endfunction

    // Clamp a time value to the output field.
    function automatic t_out sat_out(input t_time v);
        logic [WideBits-1:0] wide;
        wide = WideBits'(v);
        if (wide > WideBits'(OutMax)) begin
            return OutMax;
        end
        return OutBits'(wide);
    endfunction

    // Time value strictly above a register value.
    function automatic logic time_gt(input t_time v, input logic [CfgBits-1:0] lim);
        return WideBits'(v) > WideBits'(lim);
    endfunction

    function automatic t_pstate by_thresholds(input t_time v, input t_cfg cfg);
        if (time_gt(v, cfg.threshold_sleep)) begin
            return PS_SLEEP;
        end
        if (time_gt(v, cfg.threshold_idle)) begin
            return PS_IDLE;
        end
        return PS_RUN;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dynamic_power_state_policy_unit.sv -----
// Top level of the dynamic power state policy unit: registers, handshakes, config.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-----------------------------------------
//  in       | input     | i_in_valid / o_in_ready   | i_mode, i_work_duration
//  out      | output    | o_out_valid / i_out_ready | o_power_state, o_state_changed,
//           |           |                           | o_predicted_idle
//  cfg      | input     | i_cfg_we (no wait)        | i_cfg_index, i_cfg_wdata
//
// One transaction per cycle sustained while the output is not stalled; a result passes
// through the input register and then the result register. The policy update between
// the two registers is combinational: it holds the multiply-add of the exponential average
// and the threshold compares, and the policy state is written with the result register.
// Reset (i_rst_n low, synchronous) clears both pipeline registers, the policy state
// and loads register defaults (alpha at one half, all else zero).
// A stalled output holds its result; the input register still takes one transaction.
`default_nettype none

module dynamic_power_state_policy_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_mode,
    input  logic [dpsp_pkg::DurBits-1:0]           i_work_duration,
    // output channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [1:0]                             o_power_state,
    output logic                                   o_state_changed,
    output logic [dpsp_pkg::OutBits-1:0]           o_predicted_idle,
    // configuration writes
    input  logic                                   i_cfg_we,
    input  logic [dpsp_pkg::IndexBits-1:0]         i_cfg_index,
    input  logic [dpsp_pkg::CfgBits-1:0]           i_cfg_wdata
);

    dpsp_pkg::t_cfg                    r_cfg;
    dpsp_pkg::t_state                  r_state;
    dpsp_pkg::t_state                  n_state;
    dpsp_pkg::t_result                 n_res;
    dpsp_pkg::t_result                 r_out_res;
    logic                              r_in_valid;
    logic                              r_in_mode;
    logic [dpsp_pkg::DurBits-1:0]      r_in_dur;
    logic                              r_out_valid;
    logic                              w_advance;
    logic                              w_in_accept;
    dpsp_pkg::t_alpha                  w_alpha_wr;

    // Move a transaction into the result register when that register is free or draining.
    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign w_in_accept = i_in_valid && o_in_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_mode <= i_mode;
            r_in_dur  <= i_work_duration;
        end
    end

    // Decide and compute the next policy state.
    dpsp_policy u_policy (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_mode  (r_in_mode),
        .i_dur   (r_in_dur),
        .o_next  (n_state),
        .o_res   (n_res)
    );

    // Policy state: advance once per transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.cur_state    <= dpsp_pkg::PS_RUN;
            r_state.idle_ticks   <= '0;
            r_state.last_sample  <= '0;
            r_state.prediction   <= '0;
            r_state.pred_updated <= 1'b0;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_res <= n_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_power_state    = r_out_res.power_state;
    assign o_state_changed  = r_out_res.state_changed;
    assign o_predicted_idle = r_out_res.predicted_idle;

    // Configuration registers; clamp alpha at one, drop writes past the last register.
    assign w_alpha_wr = (i_cfg_wdata[dpsp_pkg::AlphaBits-1:0] > dpsp_pkg::AlphaOne)
                      ? dpsp_pkg::AlphaOne : i_cfg_wdata[dpsp_pkg::AlphaBits-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.policy          <= dpsp_pkg::POL_TIMEOUT_IDLE;
            r_cfg.timeout         <= '0;
            r_cfg.threshold_idle  <= '0;
            r_cfg.threshold_sleep <= '0;
            r_cfg.alpha           <= dpsp_pkg::t_alpha'(128);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dpsp_pkg::REG_POLICY: begin
                    r_cfg.policy <= dpsp_pkg::t_policy'(i_cfg_wdata[2:0]);
                end
                dpsp_pkg::REG_TIMEOUT: begin
                    r_cfg.timeout <= i_cfg_wdata;
                end
                dpsp_pkg::REG_THRESHOLD_IDLE: begin
                    r_cfg.threshold_idle <= i_cfg_wdata;
                end
                dpsp_pkg::REG_THRESHOLD_SLEEP: begin
                    r_cfg.threshold_sleep <= i_cfg_wdata;
                end
                dpsp_pkg::REG_ALPHA: begin
                    r_cfg.alpha <= w_alpha_wr;
                end
                default: begin
                end
            endcase
        end
    end

    // An arrival always yields RUN and opens a fresh idle period.
    a_arrival_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_mode == dpsp_pkg::MODE_ARRIVAL) |=>
        (o_power_state == dpsp_pkg::PS_RUN && r_state.idle_ticks == '0
         && !r_state.pred_updated))
        else $error("arrival did not force RUN or clear the idle period");

    // The change flag compares against the state held before the transaction.
    a_change_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> (o_state_changed == (o_power_state != $past(r_state.cur_state))))
        else $error("state_changed disagrees with previous state");

    // The stored state always matches the last delivered decision.
    a_state_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> (r_state.cur_state == o_power_state))
        else $error("policy state out of step with result");

    // A full input register that cannot drain must refuse new transactions.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |-> !o_in_ready)
        else $error("input register overrun");

endmodule

`default_nettype wire

// ----- hw/rtl/dpsp_policy.sv -----
// Policy decision and state update for one transaction.
`default_nettype none

module dpsp_policy (
    input  dpsp_pkg::t_cfg                    i_cfg,
    input  dpsp_pkg::t_state                  i_state,
    input  logic                              i_mode,
    input  logic [dpsp_pkg::DurBits-1:0]      i_dur,
    output dpsp_pkg::t_state                  o_next,
    output dpsp_pkg::t_result                 o_res
);

    localparam int ProdBits = dpsp_pkg::TimeBits + dpsp_pkg::AlphaBits;
    localparam int AccBits  = ProdBits + 1;

    logic [ProdBits-1:0]         w_prod_new;
    logic [ProdBits-1:0]         w_prod_old;
    logic [AccBits-1:0]          w_acc;
    logic [AccBits-9:0]          w_acc_shr;
    dpsp_pkg::t_alpha            w_alpha_inv;
    dpsp_pkg::t_time             w_new_pred;
    dpsp_pkg::t_time             w_pred;
    dpsp_pkg::t_time             w_dur;
    dpsp_pkg::t_time             w_shown;
    dpsp_pkg::t_pstate           w_ps;

    // Exponential average: alpha weights the newest sample, round half up.
    assign w_alpha_inv = dpsp_pkg::AlphaOne - i_cfg.alpha;
    assign w_prod_new  = ProdBits'(i_cfg.alpha) * ProdBits'(i_state.last_sample);
    assign w_prod_old  = ProdBits'(w_alpha_inv) * ProdBits'(i_state.prediction);
    assign w_acc       = AccBits'(w_prod_new) + AccBits'(w_prod_old)
                       + AccBits'(dpsp_pkg::RoundBit);
    assign w_acc_shr   = w_acc[AccBits-1:8];
    assign w_new_pred  = (w_acc_shr > (AccBits-8)'(dpsp_pkg::TimeMax))
                       ? dpsp_pkg::TimeMax : dpsp_pkg::TimeBits'(w_acc_shr);

    // Update once per idle period.
    assign w_pred = i_state.pred_updated ? i_state.prediction : w_new_pred;
    assign w_dur  = dpsp_pkg::sat_dur(i_dur);

    always_comb begin
        o_next  = i_state;
        w_ps    = dpsp_pkg::PS_RUN;
        w_shown = '0;
        if (i_mode == dpsp_pkg::MODE_TICK) begin
            case (i_cfg.policy)
                dpsp_pkg::POL_TIMEOUT_IDLE, dpsp_pkg::POL_TIMEOUT_SLEEP: begin
                    if (dpsp_pkg::time_gt(i_state.idle_ticks, i_cfg.timeout)) begin
                        w_ps = (i_cfg.policy == dpsp_pkg::POL_TIMEOUT_IDLE)
                             ? dpsp_pkg::PS_IDLE : dpsp_pkg::PS_SLEEP;
                    end
                    w_shown = i_state.idle_ticks;
                end
                dpsp_pkg::POL_LAST_ACTIVE, dpsp_pkg::POL_LAST_IDLE: begin
                    w_ps    = dpsp_pkg::by_thresholds(i_state.last_sample, i_cfg);
                    w_shown = i_state.last_sample;
                end
                dpsp_pkg::POL_EXP_AVERAGE: begin
                    o_next.prediction   = w_pred;
                    o_next.pred_updated = 1'b1;
                    w_ps                = dpsp_pkg::by_thresholds(w_pred, i_cfg);
                    w_shown             = w_pred;
                end
                default: begin
                end
            endcase
            if (i_state.idle_ticks != dpsp_pkg::TimeMax) begin
                o_next.idle_ticks = i_state.idle_ticks + dpsp_pkg::TimeBits'(1);
            end
        end else begin
            case (i_cfg.policy)
                dpsp_pkg::POL_LAST_ACTIVE: begin
                    o_next.last_sample = w_dur;
                    w_shown            = w_dur;
                end
                dpsp_pkg::POL_LAST_IDLE: begin
                    o_next.last_sample = i_state.idle_ticks;
                    w_shown            = i_state.idle_ticks;
                end
                dpsp_pkg::POL_EXP_AVERAGE: begin
                    o_next.last_sample = w_dur;
                    w_shown            = i_state.prediction;
                end
                default: begin
                end
            endcase
            o_next.idle_ticks   = '0;
            o_next.pred_updated = 1'b0;
        end
        o_next.cur_state     = w_ps;
        o_res.power_state    = w_ps;
        o_res.state_changed  = (w_ps != i_state.cur_state);
        o_res.predicted_idle = dpsp_pkg::sat_out(w_shown);
    end

endmodule

`default_nettype wire
